/* rtl/sed_pkg.sv */
package sed_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 16;
    localparam int LENGTH_W  = 19;
    localparam int COUNT_W   = 20;
    localparam int ENERGY_W  = 27;
    localparam int MAG_W     = 17;
    localparam int DEF_MAX_FRAME_SAMPLES = 1024;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_QUIET_LEVEL = 2'd0,
        REG_MIN_STREAM  = 2'd1,
        REG_QUIET_RUN   = 2'd2,
        REG_MAX_STREAM  = 2'd3
    } sed_reg_idx_t;

    localparam logic [LEVEL_W-1:0]  RST_QUIET_LEVEL = LEVEL_W'(180);
    localparam logic [LENGTH_W-1:0] RST_MIN_STREAM  = LENGTH_W'(8000);
    localparam logic [LENGTH_W-1:0] RST_QUIET_RUN   = LENGTH_W'(12800);
    localparam logic [LENGTH_W-1:0] RST_MAX_STREAM  = LENGTH_W'(128000);

    localparam logic [1:0] MODE_AUDIO = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_PAUSE = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_last;
    } sed_in_t;

    typedef struct packed {
        logic forward;
        logic streaming;
        logic quiet_frame;
        logic stream_stop;
    } sed_out_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  quiet_level;
        logic [LENGTH_W-1:0] min_stream_length;
        logic [LENGTH_W-1:0] quiet_run_length;
        logic [LENGTH_W-1:0] max_stream_length;
    } sed_cfg_t;

endpackage

/* rtl/sed_cfg_regs.sv */
module sed_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sed_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sed_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sed_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output sed_pkg::sed_cfg_t               cfg
);
    import sed_pkg::*;

    sed_cfg_t     cfg_reg;
    sed_reg_idx_t idx;
    logic         wr_en;

    assign pready = 1'b1;
    assign idx    = sed_reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quiet_level       <= RST_QUIET_LEVEL;
            cfg_reg.min_stream_length <= RST_MIN_STREAM;
            cfg_reg.quiet_run_length  <= RST_QUIET_RUN;
            cfg_reg.max_stream_length <= RST_MAX_STREAM;
        end else if (wr_en) begin
            unique case (idx)
                REG_QUIET_LEVEL: cfg_reg.quiet_level       <= pwdata[LEVEL_W-1:0];
                REG_MIN_STREAM:  cfg_reg.min_stream_length <= pwdata[LENGTH_W-1:0];
                REG_QUIET_RUN:   cfg_reg.quiet_run_length  <= pwdata[LENGTH_W-1:0];
                REG_MAX_STREAM:  cfg_reg.max_stream_length <= pwdata[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_QUIET_LEVEL: prdata = APB_DATA_W'(cfg_reg.quiet_level);
            REG_MIN_STREAM:  prdata = APB_DATA_W'(cfg_reg.min_stream_length);
            REG_QUIET_RUN:   prdata = APB_DATA_W'(cfg_reg.quiet_run_length);
            REG_MAX_STREAM:  prdata = APB_DATA_W'(cfg_reg.max_stream_length);
            default:         prdata = '0;
        endcase
    end

endmodule

/* rtl/sed_core.sv */
module sed_core #(
    parameter int MAX_FRAME_SAMPLES = sed_pkg::DEF_MAX_FRAME_SAMPLES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  sed_pkg::sed_in_t  item,
    input  sed_pkg::sed_cfg_t cfg,
    output sed_pkg::sed_out_t res
);
    import sed_pkg::*;

    localparam int FILL_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int PROD_W = LEVEL_W + FILL_W;
    localparam int CMP_W  = (PROD_W > ENERGY_W) ? PROD_W : ENERGY_W;
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(MAX_FRAME_SAMPLES);

    logic                active_reg, active_next;
    logic [COUNT_W-1:0]  streamed_reg, streamed_next;
    logic [COUNT_W-1:0]  quiet_cnt_reg, quiet_cnt_next;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    logic [MAG_W-1:0]    mag;
    logic [ENERGY_W:0]   energy_sum;
    logic [ENERGY_W-1:0] energy_acc;
    logic [FILL_W-1:0]   fill_inc;
    logic [COUNT_W-1:0]  streamed_inc;
    logic [COUNT_W:0]    quiet_sum;
    logic [COUNT_W-1:0]  quiet_acc;
    logic [PROD_W-1:0]   level_x_fill;
    logic                frame_end;
    logic                is_quiet;

    // |sample|; -32768 gives 32768
    assign mag = item.sample[SAMPLE_W-1]
               ? MAG_W'(17'h10000 - {1'b0, item.sample})
               : {1'b0, item.sample};

    assign energy_sum   = {1'b0, energy_reg} + (ENERGY_W+1)'(mag);
    assign energy_acc   = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    assign fill_inc     = fill_reg + FILL_W'(1);
    assign streamed_inc = (streamed_reg == COUNT_MAX) ? COUNT_MAX
                                                      : streamed_reg + COUNT_W'(1);
    assign frame_end    = item.frame_last || (fill_inc >= FILL_LIMIT);

    // floor(E/F) < Q  <=>  E < Q*F, so no divider is needed
    assign level_x_fill = PROD_W'(cfg.quiet_level) * PROD_W'(fill_inc);
    assign is_quiet     = (streamed_inc >= COUNT_W'(cfg.min_stream_length))
                       && (CMP_W'(energy_acc) < CMP_W'(level_x_fill));

    assign quiet_sum = {1'b0, quiet_cnt_reg} + (COUNT_W+1)'(fill_inc);
    assign quiet_acc = quiet_sum[COUNT_W] ? COUNT_MAX : quiet_sum[COUNT_W-1:0];

    always_comb begin
        active_next    = active_reg;
        streamed_next  = streamed_reg;
        quiet_cnt_next = quiet_cnt_reg;
        energy_next    = energy_reg;
        fill_next      = fill_reg;
        res            = '0;

        if (item.mode == MODE_START) begin
            if (!active_reg) begin
                active_next    = 1'b1;
                streamed_next  = '0;
                quiet_cnt_next = '0;
                energy_next    = '0;
                fill_next      = '0;
            end
        end else if (item.mode == MODE_PAUSE) begin
            energy_next = '0;
            fill_next   = '0;
            if (active_reg) begin
                active_next     = 1'b0;
                res.stream_stop = 1'b1;
            end
        end else if (item.mode == MODE_AUDIO && active_reg) begin
            res.forward   = 1'b1;
            streamed_next = streamed_inc;
            energy_next   = energy_acc;
            fill_next     = fill_inc;
            if (frame_end) begin
                energy_next = '0;
                fill_next   = '0;
                if (is_quiet) begin
                    res.quiet_frame = 1'b1;
                    quiet_cnt_next  = quiet_acc;
                end else begin
                    quiet_cnt_next  = '0;
                end
                if (streamed_inc >= COUNT_W'(cfg.max_stream_length) ||
                    quiet_cnt_next >= COUNT_W'(cfg.quiet_run_length)) begin
                    active_next     = 1'b0;
                    res.stream_stop = 1'b1;
                end
            end
        end
        res.streaming = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            streamed_reg  <= '0;
            quiet_cnt_reg <= '0;
            energy_reg    <= '0;
            fill_reg      <= '0;
        end else if (en) begin
            active_reg    <= active_next;
            streamed_reg  <= streamed_next;
            quiet_cnt_reg <= quiet_cnt_next;
            energy_reg    <= energy_next;
            fill_reg      <= fill_next;
        end
    end

    a_quiet_needs_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        en && res.quiet_frame |-> item.mode == MODE_AUDIO && active_reg)
        else $error("quiet frame flagged outside an active audio transfer");

    a_stop_ends_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        en && res.stream_stop |=> !active_reg)
        else $error("stream still active after stop");

    a_forward_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        en && res.forward |=> streamed_reg != '0)
        else $error("forwarded sample not counted");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_LIMIT)
        else $error("frame fill reached its limit without closing the frame");

endmodule

/* rtl/speech_endpoint_detector.sv */
// Energy-based end-of-speech detector. Audio samples (mode 0) and start/pause
// commands arrive on the s_ channel; one result per transfer leaves on the m_
// channel. A transfer is taken every cycle while the result side keeps up:
// each item passes an input register, then a result register, and the
// per-sample update of the stream and frame state is combinational,
// so the sustained rate is one item per clock. The frame quiet test compares
// frame energy against quiet_level times the frame length, one 16 by
// frame-length-bit multiply. Registers sit on an APB port at byte addresses
// 0x0 quiet_level, 0x4 min_stream_length, 0x8 quiet_run_length,
// 0xC max_stream_length; write them only while no transfer is in flight.
module speech_endpoint_detector #(
    parameter int MAX_FRAME_SAMPLES = sed_pkg::DEF_MAX_FRAME_SAMPLES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sed_pkg::sed_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sed_pkg::sed_out_t               m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sed_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sed_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sed_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sed_pkg::*;

    sed_cfg_t cfg;
    sed_in_t  in_reg;
    logic     in_valid_reg;
    sed_out_t out_reg;
    sed_out_t res;
    logic     out_valid_reg;
    logic     advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    sed_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sed_core #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("pipeline not empty after reset");

    a_in_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("pending input item lost while result side stalled");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !advance)
        else $error("result overwritten before its transfer");

endmodule

/* bench/speech_endpoint_detector_tb.sv */
`timescale 1ns / 1ps

module speech_endpoint_detector_tb;
    import sed_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int FRAME_CAP    = DEF_MAX_FRAME_SAMPLES;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 300;
    localparam int DEEP_ITEMS   = 1550;
    localparam int PHASE_ITEMS  = 150;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [LENGTH_W-1:0] LEN_TOP = '1;
    localparam logic [LEVEL_W-1:0]  LEVEL_TOP = LEVEL_W'(32768);

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_style_t;
    typedef enum int {FRAME_QUIET, FRAME_LOUD, FRAME_BORDER} frame_kind_t;

    class endpoint_scoreboard;
        logic [LEVEL_W-1:0]  level;
        logic [LENGTH_W-1:0] min_len;
        logic [LENGTH_W-1:0] run_len;
        logic [LENGTH_W-1:0] max_len;
        bit                  active;
        logic [COUNT_W-1:0]  streamed;
        logic [COUNT_W-1:0]  quiet_run;
        logic [ENERGY_W-1:0] energy;
        logic [10:0]         fill;
        sed_out_t            expected_q[$];
        int                  mismatches;

        function new();
            level      = RST_QUIET_LEVEL;
            min_len    = RST_MIN_STREAM;
            run_len    = RST_QUIET_RUN;
            max_len    = RST_MAX_STREAM;
            active     = 1'b0;
            streamed   = '0;
            quiet_run  = '0;
            energy     = '0;
            fill       = '0;
            mismatches = 0;
        endfunction

        function void set_reg(sed_reg_idx_t idx, logic [APB_DATA_W-1:0] v);
            case (idx)
                REG_QUIET_LEVEL: level = v[LEVEL_W-1:0];
                REG_MIN_STREAM:  min_len = v[LENGTH_W-1:0];
                REG_QUIET_RUN:   run_len = v[LENGTH_W-1:0];
                REG_MAX_STREAM:  max_len = v[LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(sed_in_t x);
            sed_out_t         r;
            logic [MAG_W-1:0] mag;
            logic [COUNT_W:0] cnt_sum;
            logic [ENERGY_W:0] en_sum;
            int unsigned      mean;
            r = '0;
            if (x.mode == MODE_START) begin
                if (!active) begin
                    active    = 1'b1;
                    streamed  = '0;
                    quiet_run = '0;
                    energy    = '0;
                    fill      = '0;
                end
            end else if (x.mode == MODE_PAUSE) begin
                energy = '0;
                fill   = '0;
                if (active) begin
                    active = 1'b0;
                    r.stream_stop = 1'b1;
                end
            end else if (x.mode == MODE_AUDIO && active) begin
                mag = x.sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, x.sample}) : {1'b0, x.sample};
                r.forward = 1'b1;
                cnt_sum  = {1'b0, streamed} + 21'd1;
                streamed = (cnt_sum > COUNT_MAX) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
                en_sum   = {1'b0, energy} + 28'(mag);
                energy   = (en_sum > ENERGY_MAX) ? ENERGY_MAX : en_sum[ENERGY_W-1:0];
                fill     = fill + 11'd1;
                // frame closes on the mark or when it hits the size cap
                if (x.frame_last || fill >= FRAME_CAP) begin
                    mean = 32'(energy) / 32'(fill);
                    if (streamed >= min_len && mean < level) begin
                        r.quiet_frame = 1'b1;
                        cnt_sum   = {1'b0, quiet_run} + 21'(fill);
                        quiet_run = (cnt_sum > COUNT_MAX) ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
                    end else begin
                        quiet_run = '0;
                    end
                    energy = '0;
                    fill   = '0;
                    if (streamed >= max_len || quiet_run >= run_len) begin
                        active = 1'b0;
                        r.stream_stop = 1'b1;
                    end
                end
            end
            r.streaming = active;
            expected_q.push_back(r);
        endfunction

        function void report(string what, sed_out_t exp_r, sed_out_t got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: exp fwd=%0b str=%0b quiet=%0b stop=%0b,",
                         $realtime, what, exp_r.forward, exp_r.streaming,
                         exp_r.quiet_frame, exp_r.stream_stop,
                         " got fwd=%0b str=%0b quiet=%0b stop=%0b",
                         got.forward, got.streaming, got.quiet_frame,
                         got.stream_stop);
            end
        endfunction

        function void check_result(sed_out_t got);
            sed_out_t exp_r;
            if (expected_q.size() == 0) begin
                report("result with nothing pending", '0, got);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.forward !== exp_r.forward || got.streaming !== exp_r.streaming ||
                got.quiet_frame !== exp_r.quiet_frame ||
                got.stream_stop !== exp_r.stream_stop) begin
                report("result mismatch", exp_r, got);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sed_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    sed_out_t              m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    endpoint_scoreboard sb;
    int        items_sent;
    int        burst_left;
    int        hold_requests;
    int        holds_served;
    int        hold_left;
    int        style_left;
    rx_style_t rx_style;

    speech_endpoint_detector #(
        .MAX_FRAME_SAMPLES(FRAME_CAP)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    // receiver: pattern of its own, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (holds_served < hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 120);
            end
            style_left = style_left - 1;
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_ready <= ($urandom_range(0, 9) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    task automatic send_item(sed_in_t x);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left = burst_left - 1;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(x);
        items_sent++;
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        sed_in_t x;
        x.mode       = MODE_AUDIO;
        x.sample     = s;
        x.frame_last = last;
        send_item(x);
    endtask

    // sample and frame_last are don't-care for commands, so keep them random
    task automatic send_cmd(logic [1:0] mode);
        sed_in_t x;
        x.mode       = mode;
        x.sample     = SAMPLE_W'($urandom);
        x.frame_last = 1'($urandom_range(0, 1));
        send_item(x);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] signed_mag(int unsigned mag);
        if (mag >= 32768) return 16'sh8000;
        if ($urandom_range(0, 1)) return SAMPLE_W'(-int'(mag));
        return SAMPLE_W'(mag);
    endfunction

    task automatic send_frame(int len, frame_kind_t kind, bit closed);
        logic signed [SAMPLE_W-1:0] s;
        int unsigned lim;
        for (int i = 0; i < len; i++) begin
            lim = sb.level;
            case (kind)
                FRAME_QUIET: s = signed_mag((lim == 0) ? 0 : $urandom_range(lim - 1, 0));
                FRAME_LOUD:  s = SAMPLE_W'($urandom);
                default:     s = signed_mag($urandom_range(lim + 3, (lim > 3) ? lim - 3 : 0));
            endcase
            send_sample(s, closed && (i == len - 1));
        end
    endtask

    task automatic write_reg(sed_reg_idx_t idx, logic [APB_DATA_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_config(int unsigned lvl, int unsigned mn, int unsigned run,
                                int unsigned mx);
        write_reg(REG_QUIET_LEVEL, lvl);
        write_reg(REG_MIN_STREAM, mn);
        write_reg(REG_QUIET_RUN, run);
        write_reg(REG_MAX_STREAM, mx);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_stream();
        int nframes;
        int pick;
        int len;
        frame_kind_t kind;
        sed_in_t x;
        send_cmd(MODE_START);
        nframes = $urandom_range(1, 10);
        repeat (nframes) begin
            if ($urandom_range(0, 15) == 0) begin
                send_cmd($urandom_range(0, 1) ? MODE_START : MODE_UNUSED);
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
            pick = $urandom_range(0, 9);
            if (pick < 5) kind = FRAME_QUIET;
            else if (pick < 8) kind = FRAME_LOUD;
            else kind = FRAME_BORDER;
            send_frame(len, kind, 1'b1);
        end
        case ($urandom_range(0, 3))
            0: begin
                // partial frame dropped by pause
                send_frame($urandom_range(1, 5), FRAME_LOUD, 1'b0);
                send_cmd(MODE_PAUSE);
            end
            1: send_cmd(MODE_PAUSE);
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                x.mode       = 2'($urandom_range(0, 3));
                x.sample     = SAMPLE_W'($urandom);
                x.frame_last = 1'($urandom_range(0, 1));
                send_item(x);
            end
        end
    endtask

    initial begin
        int phase;
        int deep_count;
        int phase_stop;
        int mark;
        sb = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        burst_left    = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        style_left    = 0;
        rx_style      = RX_OPEN;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: commands while idle, extremes, start while streaming
        send_cmd(MODE_PAUSE);
        send_sample(16'sh7fff, 1'b1);
        send_cmd(MODE_UNUSED);
        send_cmd(MODE_START);
        send_cmd(MODE_START);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_cmd(MODE_UNUSED);
        send_sample(16'sd5, 1'b0);
        send_cmd(MODE_PAUSE);
        send_cmd(MODE_PAUSE);
        wait_idle();
        // zero quiet run: first frame end stops the stream
        write_config(LEVEL_TOP, 0, 0, LEN_TOP);
        send_cmd(MODE_START);
        send_sample(16'sd100, 1'b1);
        send_cmd(MODE_START);
        send_sample(16'sh8000, 1'b1);
        wait_idle();
        // zero max length
        write_config(RST_QUIET_LEVEL, RST_MIN_STREAM, LEN_TOP, 0);
        send_cmd(MODE_START);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd9, 1'b1);
        send_sample(-16'sd3, 1'b1);
        wait_idle();

        phase = 0;
        deep_count = 0;
        while (deep_count < DEEP_ITEMS) begin
            phase++;
            if (phase == 1) begin
                write_config(LEVEL_TOP, 0, LEN_TOP, LEN_TOP);
            end else if (phase == 4) begin
                write_config(0, LEN_TOP, 0, 0);
            end else if (phase % 5 == 2) begin
                write_config(LEVEL_TOP, 0, 0, $urandom_range(0, 200));
            end else begin
                write_config($urandom_range(50, 4000), $urandom_range(0, 80),
                             $urandom_range(1, 150), $urandom_range(30, 500));
            end
            if (phase % 3 == 2) hold_requests++;
            phase_stop = deep_count + PHASE_ITEMS;
            if (phase == 1) begin
                // oversize frame: closes itself at the cap
                mark = items_sent;
                send_cmd(MODE_PAUSE);
                send_cmd(MODE_START);
                send_frame(FRAME_CAP + $urandom_range(1, 40), FRAME_QUIET, 1'b0);
                send_sample(SAMPLE_W'($urandom), 1'b1);
                deep_count += items_sent - mark;
            end
            while (deep_count < phase_stop) begin
                mark = items_sent;
                run_stream();
                deep_count += items_sent - mark;
            end
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
